@@ sv/rhd_pkg.sv @@
// Shared types and constants for the record header deframer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rhd_pkg;

    localparam int DATA_W      = 8;
    localparam int GROUP_W     = 7;
    localparam int ID_W        = 14;
    localparam int LEN_W       = 28;
    localparam int OFF_W       = 32;
    localparam int M_TDATA_W   = 80;
    localparam int M_TUSER_W   = 2;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam int ID_GROUPS_DEF     = 2;
    localparam int LENGTH_GROUPS_DEF = 4;
    localparam int POSITION_BITS_DEF = 32;

    localparam logic [ID_W-1:0] CELL_LOW_RST  = ID_W'(1);
    localparam logic [ID_W-1:0] CELL_HIGH_RST = ID_W'(11);

    // register indexes, taken from paddr[2]
    localparam logic REG_CELL_LOW  = 1'b0;
    localparam logic REG_CELL_HIGH = 1'b1;

    // m_tdata field positions, lowest bit first
    localparam int TD_ID_LSB    = 0;
    localparam int TD_LEN_LSB   = TD_ID_LSB + ID_W;
    localparam int TD_OFF_LSB   = TD_LEN_LSB + LEN_W;
    localparam int TD_TRUNC_BIT = TD_OFF_LSB + OFF_W;

    // m_tuser bit positions
    localparam int TU_REC_BIT  = 0;
    localparam int TU_CELL_BIT = 1;

    typedef struct packed {
        logic [ID_W-1:0] low;
        logic [ID_W-1:0] high;
    } rhd_cell_range_t;

    typedef struct packed {
        logic             valid;
        logic             record_valid;
        logic [ID_W-1:0]  header_id;
        logic [LEN_W-1:0] record_length;
        logic [OFF_W-1:0] content_offset;
        logic             is_cell;
        logic             stream_end;
        logic             truncated;
    } rhd_result_t;

endpackage

`default_nettype wire

@@ sv/rhd_cfg.sv @@
// APB-style register file for the cell id range.
// Depends on rhd_pkg.
`default_nettype none

module rhd_cfg
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rhd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [rhd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [rhd_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready,
    output rhd_pkg::rhd_cell_range_t            cell_range
);
    import rhd_pkg::*;

    logic [ID_W-1:0] cell_low_reg;
    logic [ID_W-1:0] cell_high_reg;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_low_reg  <= CELL_LOW_RST;
            cell_high_reg <= CELL_HIGH_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_CELL_LOW:  cell_low_reg  <= pwdata[ID_W-1:0];
                REG_CELL_HIGH: cell_high_reg <= pwdata[ID_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CELL_LOW:  prdata = APB_DATA_W'(cell_low_reg);
            REG_CELL_HIGH: prdata = APB_DATA_W'(cell_high_reg);
            default:       prdata = '0;
        endcase
    end

    assign cell_range.low  = cell_low_reg;
    assign cell_range.high = cell_high_reg;

endmodule

`default_nettype wire

@@ sv/rhd_parse.sv @@
// Header decoder: holds the parse state and works out one byte per step.
// Depends on rhd_pkg; fed from the input register of the top level.
`default_nettype none

module rhd_parse
#(
    parameter int ID_GROUPS     = rhd_pkg::ID_GROUPS_DEF,
    parameter int LENGTH_GROUPS = rhd_pkg::LENGTH_GROUPS_DEF,
    parameter int POSITION_BITS = rhd_pkg::POSITION_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [rhd_pkg::DATA_W-1:0]  data_byte,
    input  wire logic                        last_byte,
    input  rhd_pkg::rhd_cell_range_t          cell_range,
    output rhd_pkg::rhd_result_t              result
);
    import rhd_pkg::*;

    localparam int MAX_GROUPS = (ID_GROUPS > LENGTH_GROUPS) ? ID_GROUPS : LENGTH_GROUPS;
    localparam int GI_W       = (MAX_GROUPS > 2) ? $clog2(MAX_GROUPS) : 1;
    localparam int SH_W       = $clog2(GROUP_W * (2 ** GI_W));

    typedef enum logic [2:0] {
        PH_ID   = 3'b001,
        PH_LEN  = 3'b010,
        PH_SKIP = 3'b100
    } phase_t;

    phase_t                   phase_reg,   phase_next;
    logic [GI_W-1:0]          gi_reg,      gi_next;
    logic [ID_W-1:0]          id_reg,      id_next;
    logic [LEN_W-1:0]         len_reg,     len_next;
    logic [LEN_W-1:0]         skip_reg,    skip_next;
    logic [POSITION_BITS-1:0] pos_reg,     pos_next;

    logic [GROUP_W-1:0]       grp;
    logic                     more;
    logic [GI_W:0]            gi_inc;
    logic [SH_W-1:0]          shamt;
    logic [LEN_W-1:0]         shifted;
    logic [ID_W-1:0]          id_new;
    logic [LEN_W-1:0]         len_new;
    logic [LEN_W-1:0]         skip_dec;
    logic                     id_done;
    logic                     len_done;
    logic                     rec_valid;
    logic [ID_W-1:0]          rec_id;
    logic [LEN_W-1:0]         rec_len;
    logic                     res_valid;
    logic                     res_trunc;

    assign grp      = data_byte[GROUP_W-1:0];
    assign more     = data_byte[DATA_W-1];
    assign gi_inc   = {1'b0, gi_reg} + 1'b1;
    assign shamt    = SH_W'(GROUP_W * int'(gi_reg));
    assign shifted  = LEN_W'(grp) << shamt;
    assign id_new   = ((gi_reg == '0) ? '0 : id_reg) | shifted[ID_W-1:0];
    assign len_new  = len_reg | shifted;
    assign skip_dec = skip_reg - 1'b1;
    assign id_done  = !more || (gi_inc >= (GI_W+1)'(ID_GROUPS));
    assign len_done = !more || (gi_inc >= (GI_W+1)'(LENGTH_GROUPS));
    assign pos_next = pos_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        gi_next    = gi_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        skip_next  = skip_reg;
        rec_valid  = 1'b0;
        rec_id     = id_reg;
        rec_len    = '0;
        res_valid  = 1'b0;
        res_trunc  = 1'b0;

        unique case (phase_reg)
            PH_ID:
            begin
                id_next   = id_new;
                rec_id    = id_new;
                res_valid = last_byte;
                res_trunc = 1'b1;
                if (id_done)
                begin
                    phase_next = PH_LEN;
                    gi_next    = '0;
                    len_next   = '0;
                    rec_valid  = 1'b1;
                end
                else
                begin
                    gi_next = gi_inc[GI_W-1:0];
                end
            end
            PH_LEN:
            begin
                rec_valid = 1'b1;
                res_valid = last_byte;
                if (len_done)
                begin
                    rec_len   = len_new;
                    res_valid = 1'b1;
                    res_trunc = last_byte && (len_new != '0);
                    gi_next   = '0;
                    skip_next = len_new;
                    phase_next = (len_new != '0) ? PH_SKIP : PH_ID;
                end
                else
                begin
                    len_next  = len_new;
                    gi_next   = gi_inc[GI_W-1:0];
                    res_trunc = 1'b1;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = PH_ID;
                end
                res_valid = last_byte;
                res_trunc = (skip_dec != '0);
            end
            default:
            begin
                phase_next = PH_ID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ID;
            gi_reg    <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            skip_reg  <= '0;
            pos_reg   <= '0;
        end
        else if (step)
        begin
            // a stream end puts every parse register back to its reset value
            if (last_byte)
            begin
                phase_reg <= PH_ID;
                gi_reg    <= '0;
                id_reg    <= '0;
                len_reg   <= '0;
                skip_reg  <= '0;
                pos_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                gi_reg    <= gi_next;
                id_reg    <= id_next;
                len_reg   <= len_next;
                skip_reg  <= skip_next;
                pos_reg   <= pos_next;
            end
        end
    end

    always_comb
    begin
        result.valid          = res_valid;
        result.record_valid   = rec_valid;
        result.header_id      = rec_valid ? rec_id : '0;
        result.record_length  = rec_valid ? rec_len : '0;
        result.content_offset = rec_valid ? OFF_W'(pos_next) : '0;
        result.is_cell        = rec_valid && (rec_id >= cell_range.low)
                                && (rec_id <= cell_range.high);
        result.stream_end     = last_byte;
        result.truncated      = res_trunc;
    end

endmodule

`default_nettype wire

@@ sv/record_header_deframer.sv @@
// Top level of the record header deframer: input register, decoder, result register.
// Depends on rhd_pkg, rhd_cfg and rhd_parse.
`default_nettype none

// Takes one stream byte per cycle on the s_ side while m_tready stays high
// and reports each record header as it completes, and each stream end, as an
// item on the m_ side; a header closed by the last byte shares its item with
// the stream end. A byte is held in the input register and then decoded into
// the result register, from which its result is offered. Bytes are taken back
// to back at one per cycle while m_tready stays high; a stalled result holds
// the decoder, and one more byte waits in the input register. Bytes that
// neither close a header nor end the stream give no output. The cell id
// range registers sit at byte addresses 0 and 4.
module record_header_deframer
#(
    parameter int ID_GROUPS     = rhd_pkg::ID_GROUPS_DEF,
    parameter int LENGTH_GROUPS = rhd_pkg::LENGTH_GROUPS_DEF,
    parameter int POSITION_BITS = rhd_pkg::POSITION_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [rhd_pkg::DATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  wire logic                           s_tlast,   // last_byte
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [13:0] header id, [41:14] record_length, [73:42] content_offset,
    // [74] truncated, [79:75] zero
    output logic      [rhd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic      [rhd_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] record_valid, [1] is_cell
    output logic                                m_tlast,   // stream_end
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rhd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [rhd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [rhd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import rhd_pkg::*;

    rhd_cell_range_t    cell_range;
    rhd_result_t        result;

    logic               in_valid_reg;
    logic [DATA_W-1:0]  in_byte_reg;
    logic               in_last_reg;
    logic               step;

    logic               out_valid_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic [OFF_W-1:0]   out_off_reg;
    logic               out_trunc_reg;
    logic               out_rec_reg;
    logic               out_cell_reg;
    logic               out_end_reg;

    rhd_cfg u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cell_range (cell_range)
    );

    // advance the decoder only when the result register can take its output
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    rhd_parse
    #(
        .ID_GROUPS     (ID_GROUPS),
        .LENGTH_GROUPS (LENGTH_GROUPS),
        .POSITION_BITS (POSITION_BITS)
    )
    u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .cell_range (cell_range),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.valid)
        begin
            out_id_reg    <= result.header_id;
            out_len_reg   <= result.record_length;
            out_off_reg   <= result.content_offset;
            out_trunc_reg <= result.truncated;
            out_rec_reg   <= result.record_valid;
            out_cell_reg  <= result.is_cell;
            out_end_reg   <= result.stream_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_trunc_reg, out_off_reg, out_len_reg, out_id_reg});
    assign m_tuser  = {out_cell_reg, out_rec_reg};
    assign m_tlast  = out_end_reg;

endmodule

`default_nettype wire

@@ sv/rhd_checker.sv @@
// Port-level checks for the record header deframer, bound to the top level.
// Depends on rhd_pkg.
`default_nettype none

module rhd_checker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [rhd_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic [rhd_pkg::M_TUSER_W-1:0] m_tuser,
    input  wire logic                          m_tlast
);
    import rhd_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result request changed");

    a_no_record_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[TU_REC_BIT] |->
            (m_tdata[TD_TRUNC_BIT-1:0] == '0) && !m_tuser[TU_CELL_BIT])
        else $error("record fields set without a record");

    a_no_record_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[TU_REC_BIT] |-> m_tlast)
        else $error("empty result without a stream end");

    a_trunc_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[TD_TRUNC_BIT] |-> m_tlast)
        else $error("truncation flagged away from a stream end");

endmodule

bind record_header_deframer rhd_checker u_rhd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
